// ----- rtl/core/b32d_pkg.sv -----
// Shared types, constants and the alphabet decode function for the Base32 decoder.
package b32d_pkg;

    localparam logic [7:0] PAD_CHAR   = 8'h3D;  // '='
    localparam logic [4:0] DIGIT_BASE = 5'd26;
    localparam logic [7:0] CHAR_UC_A  = 8'h41;
    localparam logic [7:0] CHAR_UC_Z  = 8'h5A;
    localparam logic [7:0] CHAR_LC_A  = 8'h61;
    localparam logic [7:0] CHAR_LC_Z  = 8'h7A;
    localparam logic [7:0] CHAR_DIG_2 = 8'h32;
    localparam logic [7:0] CHAR_DIG_7 = 8'h37;

    // Default depth of the result queue; it must be at least two.
    localparam int RESULT_QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_CHAR = 2'd1,
        ST_BAD_LEN  = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_string;
        t_status    status;
    } t_result;

    // Up to two results written in one cycle; first goes ahead of second.
    typedef struct packed {
        logic [1:0] num;
        t_result    first;
        t_result    second;
    } t_qpush;

    typedef struct packed {
        logic       is_sym;
        logic [4:0] value;
    } t_sym;

    function automatic t_sym sym_decode(input logic [7:0] c);
        t_sym       s;
        logic [7:0] d;
        s = '0;
        d = '0;
        if (c >= CHAR_UC_A && c <= CHAR_UC_Z) begin
            d = c - CHAR_UC_A;
            s.is_sym = 1'b1;
            s.value  = d[4:0];
        end else if (c >= CHAR_LC_A && c <= CHAR_LC_Z) begin
            d = c - CHAR_LC_A;
            s.is_sym = 1'b1;
            s.value  = d[4:0];
        end else if (c >= CHAR_DIG_2 && c <= CHAR_DIG_7) begin
            d = c - CHAR_DIG_2;
            s.is_sym = 1'b1;
            s.value  = d[4:0] + DIGIT_BASE;
        end
        return s;
    endfunction

endpackage

// ----- rtl/core/b32d_result_queue.sv -----
// Small result queue that takes up to two results per cycle and gives one per transaction.
module b32d_result_queue #(
    parameter int Depth = b32d_pkg::RESULT_QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  b32d_pkg::t_qpush  i_push,
    output logic              o_room2,
    output logic              o_valid,
    input  logic              i_stall,
    output b32d_pkg::t_result o_res
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastIdx = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] CntRoom = CntW'(Depth - 2);

    b32d_pkg::t_result r_mem [Depth];
    logic [PtrW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0]   r_count, n_count;
    logic [PtrW-1:0]   wr_ptr1;
    logic              pop;

    function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
        return (p == LastIdx) ? '0 : p + 1'b1;
    endfunction

    assign o_valid = (r_count != '0);
    assign o_room2 = (r_count <= CntRoom);
    assign o_res   = r_mem[r_rd_ptr];
    assign pop     = o_valid && !i_stall;
    assign wr_ptr1 = ptr_inc(r_wr_ptr);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        if (i_push.num == 2'd1) begin
            n_wr_ptr = wr_ptr1;
        end else if (i_push.num == 2'd2) begin
            n_wr_ptr = ptr_inc(wr_ptr1);
        end
        n_rd_ptr = pop ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count + CntW'(i_push.num) - CntW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.first;
        end
        if (i_push.num == 2'd2) begin
            r_mem[wr_ptr1] <= i_push.second;
        end
    end

    // The queue never holds more results than it has entries.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(Depth))
        else $error("result queue overfilled");

    // Writes only arrive when the producer was told there is room for two.
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.num != 2'd0) |-> o_room2)
        else $error("result queue written without room");

endmodule

// ----- rtl/core/base32_decoder.sv -----
// Top level of the streaming Base32 decoder: character decode, bit packing and result queue.
//
//  Channel   Direction  Handshake            Payload
//  --------  ---------  -------------------  ----------------------------------------
//  input     in         i_valid / o_stall    i_ch, i_has_char, i_is_last
//  result    out        o_valid / i_stall    o_data_byte, o_end_of_string, o_status
//
// One character transaction is taken per cycle while o_stall is low. Its decode, the
// five-bit append to the accumulator and the byte extraction are done in the cycle of
// acceptance, and the results go into the result queue, whose head is the output register.
// A character can cause two results (its data byte and the closing status), so the
// result channel moves at most one per cycle; o_stall rises while the queue has fewer
// than two free entries. Reset is synchronous and clears all string state and the queue.
module base32_decoder #(
    parameter int QueueDepth = b32d_pkg::RESULT_QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_ch,
    input  logic       i_has_char,
    input  logic       i_is_last,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_data_byte,
    output logic       o_end_of_string,
    output logic [1:0] o_status
);

    // String state. Only the low r_bit_count bits of the accumulator are pending data.
    logic [11:0]       r_acc, n_acc;
    logic [3:0]        r_bit_count, n_bit_count;
    logic [2:0]        r_phase, n_phase;
    logic              r_pad_seen, n_pad_seen;
    b32d_pkg::t_status r_err, n_err;

    logic              accept;
    logic              room2;
    b32d_pkg::t_sym    sym;
    logic              is_pad;
    logic              is_data;
    logic              is_bad;
    logic              do_pack;
    logic              emit;
    logic [11:0]       acc_shift;
    logic [3:0]        cnt_sum;
    logic [3:0]        byte_shift;
    logic [11:0]       acc_aligned;
    logic [7:0]        out_byte;
    b32d_pkg::t_status end_status;
    b32d_pkg::t_result byte_res;
    b32d_pkg::t_result stat_res;
    b32d_pkg::t_qpush  push;
    b32d_pkg::t_result head;

    assign o_stall = !room2;
    assign accept  = i_valid && room2;

    always_comb begin
        sym     = b32d_pkg::sym_decode(i_ch);
        is_pad  = i_has_char && (i_ch == b32d_pkg::PAD_CHAR);
        // An alphabet character after padding counts as an invalid character.
        is_data = i_has_char && sym.is_sym && !r_pad_seen;
        is_bad  = i_has_char && !is_pad && !is_data;
        // Once an error is recorded, characters are only checked, not unpacked.
        do_pack = is_data && (r_err == b32d_pkg::ST_OK);

        acc_shift   = {r_acc[6:0], sym.value};
        cnt_sum     = r_bit_count + 4'd5;
        emit        = do_pack && (cnt_sum >= 4'd8);
        byte_shift  = cnt_sum - 4'd8;
        acc_aligned = acc_shift >> byte_shift;
        out_byte    = acc_aligned[7:0];

        n_acc       = r_acc;
        n_bit_count = r_bit_count;
        if (do_pack) begin
            n_acc       = acc_shift;
            n_bit_count = emit ? byte_shift : cnt_sum;
        end
        n_phase    = r_phase + 3'(is_data);
        n_pad_seen = r_pad_seen || is_pad;
        n_err      = r_err;
        if (is_bad && (r_err == b32d_pkg::ST_OK)) begin
            n_err = b32d_pkg::ST_BAD_CHAR;
        end

        // A data-character count of one, three or six modulo eight cannot end a string.
        end_status = n_err;
        if ((n_err == b32d_pkg::ST_OK) &&
            ((n_phase == 3'd1) || (n_phase == 3'd3) || (n_phase == 3'd6))) begin
            end_status = b32d_pkg::ST_BAD_LEN;
        end

        byte_res.data_byte     = out_byte;
        byte_res.end_of_string = 1'b0;
        byte_res.status        = b32d_pkg::ST_OK;
        stat_res.data_byte     = '0;
        stat_res.end_of_string = 1'b1;
        stat_res.status        = end_status;

        push.num    = 2'd0;
        push.first  = stat_res;
        push.second = stat_res;
        if (accept) begin
            push.num   = 2'(emit) + 2'(i_is_last);
            push.first = emit ? byte_res : stat_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_bit_count <= '0;
            r_phase     <= '0;
            r_pad_seen  <= 1'b0;
            r_err       <= b32d_pkg::ST_OK;
        end else if (accept) begin
            if (i_is_last) begin
                // The status closes the string; the next one starts from clean state.
                r_acc       <= '0;
                r_bit_count <= '0;
                r_phase     <= '0;
                r_pad_seen  <= 1'b0;
                r_err       <= b32d_pkg::ST_OK;
            end else begin
                r_acc       <= n_acc;
                r_bit_count <= n_bit_count;
                r_phase     <= n_phase;
                r_pad_seen  <= n_pad_seen;
                r_err       <= n_err;
            end
        end
    end

    b32d_result_queue #(
        .Depth(QueueDepth)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .o_room2(room2),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_res  (head)
    );

    assign o_data_byte     = head.data_byte;
    assign o_end_of_string = head.end_of_string;
    assign o_status        = head.status;

    // Fewer than eight bits stay pending between transactions.
    a_bits_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_count < 4'd8)
        else $error("bit count out of range");

    // A data-byte result always carries an ok status.
    a_byte_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_end_of_string) |-> (o_status == 2'(b32d_pkg::ST_OK)))
        else $error("data byte with non-ok status");

    // A closing status result carries a zero data byte.
    a_status_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_end_of_string) |-> (o_data_byte == 8'd0))
        else $error("status result with nonzero byte");

    // Once an error is recorded, no more data bytes are produced for the string.
    a_no_byte_after_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != b32d_pkg::ST_OK) |-> !emit)
        else $error("data byte after error");

endmodule
